FILE: design/xsid_pkg.sv
// ----------------------------------------------------------------------------
// xsid_pkg
// Shared types, codes and decode helpers for the x86 subset decoder.
// ----------------------------------------------------------------------------
package xsid_pkg;

	localparam logic [3:0] KIND_XOR   = 4'd0;
	localparam logic [3:0] KIND_PUSH  = 4'd1;
	localparam logic [3:0] KIND_ADD   = 4'd2;
	localparam logic [3:0] KIND_SUB   = 4'd3;
	localparam logic [3:0] KIND_CMP   = 4'd4;
	localparam logic [3:0] KIND_MOVST = 4'd5;
	localparam logic [3:0] KIND_MOVLD = 4'd6;
	localparam logic [3:0] KIND_UNIMP = 4'd7;
	localparam logic [3:0] KIND_TRUNC = 4'd8;

	localparam logic [1:0] SIZE_16 = 2'd0;
	localparam logic [1:0] SIZE_32 = 2'd1;
	localparam logic [1:0] SIZE_64 = 2'd2;

	localparam logic [2:0] SEG_CS   = 3'd0;
	localparam logic [2:0] SEG_SS   = 3'd1;
	localparam logic [2:0] SEG_DS   = 3'd2;
	localparam logic [2:0] SEG_ES   = 3'd3;
	localparam logic [2:0] SEG_FS   = 3'd4;
	localparam logic [2:0] SEG_GS   = 3'd5;
	localparam logic [2:0] SEG_NONE = 3'd6;

	localparam logic [7:0] OP_SIZE_PFX = 8'h66;
	localparam logic [7:0] OP_XOR      = 8'h31;
	localparam logic [7:0] OP_GRP1     = 8'h81;
	localparam logic [7:0] OP_GRP1_I8  = 8'h83;
	localparam logic [7:0] OP_MOV_ST   = 8'h89;
	localparam logic [7:0] OP_MOV_LD   = 8'h8b;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
		logic       seg_vld;
		logic [2:0] seg;
		logic       is_osz;
		logic       is_rex;
		logic       has_modrm;
	} entry_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [7:0]  opcode;
		logic [1:0]  operand_size;
		logic [2:0]  segment;
		logic [4:0]  rex;
		logic [7:0]  modrm_byte;
		logic [7:0]  sib_byte;
		logic [31:0] displacement;
		logic [2:0]  disp_bytes;
		logic [31:0] immediate;
		logic [2:0]  imm_bytes;
		logic [3:0]  length;
	} rec_t;

	function automatic logic [3:0] kind_of(input logic [7:0] op, input logic [7:0] modrm);
		logic [2:0] reg_f;
		logic [3:0] k;
		reg_f = modrm[5:3];
		k = KIND_UNIMP;
		if (op == OP_XOR) begin
			k = KIND_XOR;
		end else if (op[7:3] == 5'b01010) begin
			k = KIND_PUSH;
		end else if (op == OP_GRP1) begin
			if (reg_f == 3'd0) k = KIND_ADD;
			else if (reg_f == 3'd5) k = KIND_SUB;
			else if (reg_f == 3'd7) k = KIND_CMP;
		end else if (op == OP_GRP1_I8) begin
			if (reg_f == 3'd7) k = KIND_CMP;
		end else if (op == OP_MOV_ST) begin
			k = KIND_MOVST;
		end else if (op == OP_MOV_LD) begin
			k = KIND_MOVLD;
		end
		return k;
	endfunction

	function automatic logic [2:0] imm_len_of(input logic [7:0] op, input logic rex_w,
			input logic [1:0] size);
		logic [2:0] n;
		n = 3'd0;
		if (op == OP_GRP1) n = (!rex_w && size == SIZE_16) ? 3'd2 : 3'd4;
		else if (op == OP_GRP1_I8) n = 3'd1;
		return n;
	endfunction

	function automatic logic [31:0] acc_byte(input logic [31:0] acc, input logic [1:0] idx,
			input logic [7:0] b, input logic be);
		logic [31:0] r;
		if (be) begin
			r = {acc[23:0], b};
		end else begin
			case (idx)
				2'd0: r = acc | {24'd0, b};
				2'd1: r = acc | {16'd0, b, 8'd0};
				2'd2: r = acc | {8'd0, b, 16'd0};
				default: r = acc | {b, 24'd0};
			endcase
		end
		return r;
	endfunction

endpackage

FILE: design/xsid_front.sv
// ----------------------------------------------------------------------------
// xsid_front
// Input stage: registers each code byte and tags it as prefix or opcode class.
// ----------------------------------------------------------------------------
module xsid_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	output logic              in_rdy,
	input  logic [7:0]        in_code,
	input  logic              in_last,
	output logic              push,
	input  logic              full,
	output xsid_pkg::entry_t  entry
);

	logic             v_s1;
	xsid_pkg::entry_t entry_s1;
	xsid_pkg::entry_t tag;
	logic             accept;

	always_comb begin
		tag = '0;
		tag.code = in_code;
		tag.last = in_last;
		tag.seg_vld = 1'b1;
		unique case (in_code)
			8'h2e: tag.seg = xsid_pkg::SEG_CS;
			8'h36: tag.seg = xsid_pkg::SEG_SS;
			8'h3e: tag.seg = xsid_pkg::SEG_DS;
			8'h26: tag.seg = xsid_pkg::SEG_ES;
			8'h64: tag.seg = xsid_pkg::SEG_FS;
			8'h65: tag.seg = xsid_pkg::SEG_GS;
			default: begin
				tag.seg = xsid_pkg::SEG_NONE;
				tag.seg_vld = 1'b0;
			end
		endcase
		tag.is_osz = (in_code == xsid_pkg::OP_SIZE_PFX);
		tag.is_rex = (in_code[7:4] == 4'h4);
		unique case (in_code)
			8'h29, 8'h31, 8'h32, 8'h33, 8'h38, 8'h81, 8'h83, 8'h89, 8'h8b:
				tag.has_modrm = 1'b1;
			default: tag.has_modrm = 1'b0;
		endcase
	end

	assign in_rdy = !v_s1 || !full;
	assign accept = in_vld && in_rdy;
	assign push   = v_s1 && !full;
	assign entry  = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) entry_s1 <= tag;
	end

endmodule

FILE: design/xsid_queue.sv
// ----------------------------------------------------------------------------
// xsid_queue
// Short FIFO of tagged bytes between the input stage and the decode engine.
// ----------------------------------------------------------------------------
module xsid_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  xsid_pkg::entry_t  wr_entry,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output xsid_pkg::entry_t  rd_entry
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	xsid_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_entry;
	end

endmodule

FILE: design/xsid_back.sv
// ----------------------------------------------------------------------------
// xsid_back
// Decode engine: walks prefixes, opcode, ModRM, SIB, displacement, immediate
// one byte per cycle while its output slot is free; registers each record.
// ----------------------------------------------------------------------------
module xsid_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_order,
	input  logic              empty,
	output logic              pop,
	input  xsid_pkg::entry_t  e,
	output logic              out_vld,
	input  logic              out_rdy,
	output xsid_pkg::rec_t    rec
);

	localparam logic [2:0] PH_PFX0  = 3'd0;
	localparam logic [2:0] PH_PFX1  = 3'd1;
	localparam logic [2:0] PH_PFX2  = 3'd2;
	localparam logic [2:0] PH_PFX3  = 3'd3;
	localparam logic [2:0] PH_MODRM = 3'd4;
	localparam logic [2:0] PH_SIB   = 3'd5;
	localparam logic [2:0] PH_DISP  = 3'd6;
	localparam logic [2:0] PH_IMM   = 3'd7;

	logic [2:0]  phase_q,   n_phase;
	logic [2:0]  seg_q,     n_seg;
	logic [1:0]  size_q,    n_size;
	logic [4:0]  rex_q,     n_rex;
	logic [7:0]  opcode_q,  n_opcode;
	logic [7:0]  modrm_q,   n_modrm;
	logic [7:0]  sib_q,     n_sib;
	logic [31:0] disp_q,    n_disp;
	logic [2:0]  dleft_q,   n_dleft;
	logic [2:0]  dlen_q,    n_dlen;
	logic [31:0] imm_q,     n_imm;
	logic [2:0]  ileft_q,   n_ileft;
	logic [2:0]  ilen_q,    n_ilen;
	logic [3:0]  count_q,   n_count;
	logic        done;
	logic        emit;
	logic [2:0]  tail_dlen;
	logic        tail;
	logic [2:0]  tail_ilen;
	logic        out_vld_q;
	xsid_pkg::rec_t rec_q;
	xsid_pkg::rec_t rec_d;
	logic [3:0]  kind;
	logic [1:0]  dl_idx;
	logic [1:0]  il_idx;

	assign pop = !empty && (!out_vld_q || out_rdy);

	always_comb begin
		n_phase  = phase_q;
		n_seg    = seg_q;
		n_size   = size_q;
		n_rex    = rex_q;
		n_opcode = opcode_q;
		n_modrm  = modrm_q;
		n_sib    = sib_q;
		n_disp   = disp_q;
		n_dleft  = dleft_q;
		n_dlen   = dlen_q;
		n_imm    = imm_q;
		n_ileft  = ileft_q;
		n_ilen   = ilen_q;
		n_count  = (count_q != 4'd15) ? count_q + 4'd1 : count_q;
		done      = 1'b0;
		tail      = 1'b0;
		tail_dlen = 3'd0;
		dl_idx    = 2'(dlen_q - dleft_q);
		il_idx    = 2'(ilen_q - ileft_q);
		unique case (phase_q)
			PH_PFX0, PH_PFX1, PH_PFX2, PH_PFX3: begin
				if (phase_q == PH_PFX0 && e.seg_vld) begin
					n_seg   = e.seg;
					n_phase = PH_PFX1;
				end else if (phase_q <= PH_PFX1 && e.is_osz) begin
					n_size  = xsid_pkg::SIZE_16;
					n_phase = PH_PFX2;
				end else if (phase_q <= PH_PFX2 && e.is_rex) begin
					n_rex = {1'b1, e.code[3:0]};
					if (e.code[3]) n_size = xsid_pkg::SIZE_64;
					n_phase = PH_PFX3;
				end else begin
					n_opcode = e.code;
					if (e.has_modrm) n_phase = PH_MODRM;
					else done = 1'b1;
				end
			end
			PH_MODRM: begin
				n_modrm = e.code;
				if (xsid_pkg::kind_of(opcode_q, e.code) == xsid_pkg::KIND_UNIMP) begin
					done = 1'b1;
				end else if (e.code[2:0] == 3'd4 && e.code[7:6] != 2'd3) begin
					n_phase = PH_SIB;
				end else begin
					tail = 1'b1;
					unique case (e.code[7:6])
						2'd0: tail_dlen = (e.code[2:0] == 3'd5) ? 3'd4 : 3'd0;
						2'd1: tail_dlen = 3'd1;
						2'd2: tail_dlen = 3'd4;
						default: tail_dlen = 3'd0;
					endcase
				end
			end
			PH_SIB: begin
				n_sib = e.code;
				tail  = 1'b1;
				unique case (modrm_q[7:6])
					2'd1: tail_dlen = 3'd1;
					2'd2: tail_dlen = 3'd4;
					default: tail_dlen = (e.code[2:0] == 3'd5) ? 3'd4 : 3'd0;
				endcase
			end
			PH_DISP: begin
				n_disp  = xsid_pkg::acc_byte(disp_q, dl_idx, e.code, byte_order);
				n_dleft = dleft_q - 3'd1;
				if (dleft_q == 3'd1) begin
					if (ilen_q != 3'd0) n_phase = PH_IMM;
					else done = 1'b1;
				end
			end
			PH_IMM: begin
				n_imm   = xsid_pkg::acc_byte(imm_q, il_idx, e.code, byte_order);
				n_ileft = ileft_q - 3'd1;
				if (ileft_q == 3'd1) done = 1'b1;
			end
			default: n_phase = PH_PFX0;
		endcase
		tail_ilen = xsid_pkg::imm_len_of(opcode_q, rex_q[3], size_q);
		if (tail) begin
			n_dlen  = tail_dlen;
			n_dleft = tail_dlen;
			n_ilen  = tail_ilen;
			n_ileft = tail_ilen;
			if (tail_dlen != 3'd0) n_phase = PH_DISP;
			else if (tail_ilen != 3'd0) n_phase = PH_IMM;
			else done = 1'b1;
		end
	end

	assign emit = done || e.last;
	assign kind = done ? xsid_pkg::kind_of(n_opcode, n_modrm) : xsid_pkg::KIND_TRUNC;

	always_comb begin
		rec_d.kind         = kind;
		rec_d.opcode       = n_opcode;
		rec_d.operand_size = (kind == xsid_pkg::KIND_PUSH) ? xsid_pkg::SIZE_64 : n_size;
		rec_d.segment      = n_seg;
		rec_d.rex          = n_rex;
		rec_d.modrm_byte   = n_modrm;
		rec_d.sib_byte     = n_sib;
		if (!done) rec_d.displacement = '0;
		else if (n_dlen == 3'd1) rec_d.displacement = {{24{n_disp[7]}}, n_disp[7:0]};
		else rec_d.displacement = n_disp;
		rec_d.disp_bytes   = done ? n_dlen : 3'd0;
		rec_d.immediate    = done ? n_imm : '0;
		rec_d.imm_bytes    = done ? n_ilen : 3'd0;
		rec_d.length       = n_count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_PFX0;
			seg_q    <= xsid_pkg::SEG_NONE;
			size_q   <= xsid_pkg::SIZE_32;
			rex_q    <= '0;
			opcode_q <= '0;
			modrm_q  <= '0;
			sib_q    <= '0;
			disp_q   <= '0;
			dleft_q  <= '0;
			dlen_q   <= '0;
			imm_q    <= '0;
			ileft_q  <= '0;
			ilen_q   <= '0;
			count_q  <= '0;
		end else if (pop) begin
			if (emit) begin
				phase_q  <= PH_PFX0;
				seg_q    <= xsid_pkg::SEG_NONE;
				size_q   <= xsid_pkg::SIZE_32;
				rex_q    <= '0;
				opcode_q <= '0;
				modrm_q  <= '0;
				sib_q    <= '0;
				disp_q   <= '0;
				dleft_q  <= '0;
				dlen_q   <= '0;
				imm_q    <= '0;
				ileft_q  <= '0;
				ilen_q   <= '0;
				count_q  <= '0;
			end else begin
				phase_q  <= n_phase;
				seg_q    <= n_seg;
				size_q   <= n_size;
				rex_q    <= n_rex;
				opcode_q <= n_opcode;
				modrm_q  <= n_modrm;
				sib_q    <= n_sib;
				disp_q   <= n_disp;
				dleft_q  <= n_dleft;
				dlen_q   <= n_dlen;
				imm_q    <= n_imm;
				ileft_q  <= n_ileft;
				ilen_q   <= n_ilen;
				count_q  <= n_count;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (pop && emit) begin
			out_vld_q <= 1'b1;
		end else if (out_rdy) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) rec_q <= rec_d;
	end

	assign out_vld = out_vld_q;
	assign rec     = rec_q;

`ifndef SYNTHESIS
	a_mid_insn_counted: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_PFX0 |-> count_q != 4'd0)
		else $error("decoder mid-instruction with zero byte count");
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> rec_q.length != 4'd0)
		else $error("record with zero length");
	a_disp_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DISP |-> dleft_q != 3'd0)
		else $error("displacement phase with nothing left");
	a_imm_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IMM |-> (ileft_q != 3'd0 && dleft_q == 3'd0))
		else $error("immediate phase out of order");
	a_trunc_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && rec_q.kind == xsid_pkg::KIND_TRUNC) |->
		(rec_q.disp_bytes == 3'd0 && rec_q.imm_bytes == 3'd0))
		else $error("truncated record carries constants");
`endif

endmodule

FILE: design/x86_subset_instruction_decoder_top.sv
// ----------------------------------------------------------------------------
// x86_subset_instruction_decoder_top
// Byte-stream decoder for a small x86-64 subset, one record per instruction.
//
// channel   dir  handshake          content
// s_*       in   s_tvalid/s_tready  tdata[7:0] code byte, tlast last byte
// m_*       out  m_tvalid/m_tready  tuser kind, tdata decoded record fields
// cfg_*     in   cfg_we             cfg_wdata byte order (0 LSB first)
//
// One byte per cycle sustained unless the output stalls. A record passes the
// input register, queue and engine output register after its last byte is taken.
// The decode engine advances one byte per cycle whenever its output slot is
// free; a stalled output fills the queue, then drops s_tready.
// arst_n clears all control state; byte order resets to LSB first.
// ----------------------------------------------------------------------------
module x86_subset_instruction_decoder_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] code_byte
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,   // opcode, operand_size, segment, rex, modrm_byte,
	                                // sib_byte, displacement, disp_bytes, immediate,
	                                // imm_bytes, length, zero fill
	output logic [3:0]   m_tuser,   // [3:0] kind
	input  logic         cfg_we,
	input  logic         cfg_wdata
);

	logic             byte_order_q;
	logic             push;
	logic             full;
	logic             empty;
	logic             pop;
	xsid_pkg::entry_t wr_entry;
	xsid_pkg::entry_t rd_entry;
	xsid_pkg::rec_t   rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_order_q <= 1'b0;
		end else if (cfg_we) begin
			byte_order_q <= cfg_wdata;
		end
	end

	xsid_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (s_tvalid),
		.in_rdy   (s_tready),
		.in_code  (s_tdata),
		.in_last  (s_tlast),
		.push     (push),
		.full     (full),
		.entry    (wr_entry)
	);

	xsid_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.rd_entry (rd_entry)
	);

	xsid_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_order (byte_order_q),
		.empty      (empty),
		.pop        (pop),
		.e          (rd_entry),
		.out_vld    (m_tvalid),
		.out_rdy    (m_tready),
		.rec        (rec)
	);

	assign m_tuser = rec.kind;
	assign m_tdata = {4'd0, rec.length, rec.imm_bytes, rec.immediate, rec.disp_bytes,
		rec.displacement, rec.sib_byte, rec.modrm_byte, rec.rex, rec.segment,
		rec.operand_size, rec.opcode};

endmodule
